FILE: rtl/sensorless_motor_startup_sequencer_core_assert.svh
// assertion macros shared by the sequencer modules
`ifndef SENSORLESS_MOTOR_STARTUP_SEQUENCER_CORE_ASSERT_SVH
`define SENSORLESS_MOTOR_STARTUP_SEQUENCER_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SMSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// consequent checked in the cycle after the antecedent
`define SMSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

FILE: rtl/smss_pkg.sv
`default_nettype none

package smss_pkg;

  // field widths
  localparam int ANGLE_W    = 24;
  localparam int FREQ_W     = 32;
  localparam int COUNT_W    = 24;
  localparam int FUNC_W     = 2;
  localparam int PHASE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = 2 * FREQ_W;

  // ramp timeout in ticks and its counter width
  localparam int RAMP_TIMEOUT = 10000;
  localparam int RAMP_CNT_W   = 14;

  // blend weight: 16 fraction bits plus the bit for one
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int WEIGHT_W  = DIV_STEPS + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {DIV_STEPS{1'b0}}};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // angle increment: bits of freq * period above 2^28
  localparam int ANG_SHIFT = 28;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_TICKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_END      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TICKS  = 3'd5;

  // register reset values
  localparam logic [COUNT_W-1:0] RST_ALIGN_TICKS   = 24'd0;
  localparam logic [FREQ_W-1:0]  RST_FREQ_START    = 32'd5242880;
  localparam logic [FREQ_W-1:0]  RST_FREQ_END      = 32'd52428800;
  localparam logic [FREQ_W-1:0]  RST_FREQ_STEP     = 32'd1049;
  localparam logic [FREQ_W-1:0]  RST_SAMPLE_PERIOD = 32'd429497;
  localparam logic [COUNT_W-1:0] RST_SWITCH_TICKS  = 24'd0;

  // command codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2
  } func_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 3'd0,
    PH_ALIGN  = 3'd1,
    PH_RAMP   = 3'd2,
    PH_SWITCH = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RAMP_MUL,
    S_RAMP_ANGLE,
    S_SW_WEIGHT,
    S_DIV,
    S_MUL_A0,
    S_MUL_A1,
    S_ACC_A,
    S_MUL_S0,
    S_MUL_S1,
    S_ACC_S,
    S_EMIT
  } ctrl_state_t;

  // datapath operations
  typedef enum logic [4:0] {
    DP_NOP,
    DP_START,
    DP_ALIGN,
    DP_RAMP_FREQ,
    DP_RAMP_MUL,
    DP_RAMP_ANGLE,
    DP_SW_COUNT,
    DP_W_ONE,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_MUL_A0,
    DP_MUL_A1,
    DP_ACC_A,
    DP_MUL_S0,
    DP_MUL_S1,
    DP_ACC_S,
    DP_DONE_TRK,
    DP_OUT
  } dp_op_t;

  // input beat
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic               observer_converged;
    logic [ANGLE_W-1:0] observer_angle;
    logic [FREQ_W-1:0]  observer_speed;
  } in_t;

  // output beat
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [ANGLE_W-1:0] drive_angle;
    logic [FREQ_W-1:0]  drive_speed;
    logic               is_done;
  } out_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
    logic   ld_in;
    phase_t phase;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              conv;
    logic              align_hit;
    logic              mid_hit;
    logic              timeout;
    logic              sw_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/smss_dp.sv
`default_nettype none

module smss_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [smss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  smss_pkg::in_t                    in_data,
  input  smss_pkg::dp_cmd_t                cmd,
  output smss_pkg::dp_stat_t               stat,
  output smss_pkg::out_t                   out_data
);
  import smss_pkg::*;

  // configuration registers
  logic [COUNT_W-1:0] align_ticks;
  logic [FREQ_W-1:0]  freq_start;
  logic [FREQ_W-1:0]  freq_end;
  logic [FREQ_W-1:0]  freq_step;
  logic [FREQ_W-1:0]  sample_period;
  logic [COUNT_W-1:0] switch_ticks;

  // sequencer state
  in_t                   in_q;
  logic [COUNT_W-1:0]    align_count;
  logic [RAMP_CNT_W-1:0] ramp_count;
  logic [COUNT_W-1:0]    switch_count;
  logic [FREQ_W-1:0]     ramp_freq;
  logic [ANGLE_W-1:0]    angle_reg;
  logic [FREQ_W-1:0]     speed_reg;
  logic [WEIGHT_W-1:0]   mix_weight;
  logic [COUNT_W-1:0]    rem;
  logic [MUL_W-1:0]      acc;
  logic [MUL_W-1:0]      prod;
  out_t                  out_q;

  // combinational terms
  logic [COUNT_W-1:0]  align_inc;
  logic [FREQ_W:0]     freq_sum;
  logic [FREQ_W-1:0]   freq_sat;
  logic [FREQ_W-1:0]   freq_new;
  logic [FREQ_W:0]     mid_lhs;
  logic [FREQ_W:0]     mid_rhs;
  logic [COUNT_W:0]    rem2;
  logic [COUNT_W:0]    rem_diff;
  logic                div_ge;
  logic [WEIGHT_W-1:0] inv_w;
  logic [FREQ_W-1:0]   mul_a;
  logic [FREQ_W-1:0]   mul_b;
  logic [MUL_W-1:0]    mul_p;
  logic [MUL_W-1:0]    blend_sum;

  // align counter step
  assign align_inc = align_count + 1'b1;

  // ramp frequency step, saturating then clamped to the end value
  assign freq_sum = {1'b0, ramp_freq} + {1'b0, freq_step};
  assign freq_sat = freq_sum[FREQ_W] ? {FREQ_W{1'b1}} : freq_sum[FREQ_W-1:0];
  assign freq_new = (freq_sat >= freq_end) ? freq_end : freq_sat;

  // exact midpoint test
  assign mid_lhs = {ramp_freq, 1'b0};
  assign mid_rhs = {1'b0, freq_start} + {1'b0, freq_end};

  // one restoring division step per cycle
  assign rem2     = {rem, 1'b0};
  assign div_ge   = rem2 >= {1'b0, switch_ticks};
  assign rem_diff = rem2 - {1'b0, switch_ticks};

  assign inv_w = WEIGHT_ONE - mix_weight;

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      DP_RAMP_MUL: begin
        mul_a = ramp_freq;
        mul_b = sample_period;
      end
      DP_MUL_A0: begin
        mul_a = FREQ_W'(angle_reg);
        mul_b = FREQ_W'(inv_w);
      end
      DP_MUL_A1: begin
        mul_a = FREQ_W'(in_q.observer_angle);
        mul_b = FREQ_W'(mix_weight);
      end
      DP_MUL_S0: begin
        mul_a = speed_reg;
        mul_b = FREQ_W'(inv_w);
      end
      DP_MUL_S1: begin
        mul_a = in_q.observer_speed;
        mul_b = FREQ_W'(mix_weight);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign blend_sum = acc + prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      align_ticks   <= RST_ALIGN_TICKS;
      freq_start    <= RST_FREQ_START;
      freq_end      <= RST_FREQ_END;
      freq_step     <= RST_FREQ_STEP;
      sample_period <= RST_SAMPLE_PERIOD;
      switch_ticks  <= RST_SWITCH_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALIGN_TICKS:   align_ticks   <= cfg_data[COUNT_W-1:0];
        REG_FREQ_START:    freq_start    <= cfg_data[FREQ_W-1:0];
        REG_FREQ_END:      freq_end      <= cfg_data[FREQ_W-1:0];
        REG_FREQ_STEP:     freq_step     <= cfg_data[FREQ_W-1:0];
        REG_SAMPLE_PERIOD: sample_period <= cfg_data[FREQ_W-1:0];
        REG_SWITCH_TICKS:  switch_ticks  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // product, input payload and output registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.ld_in) begin
      in_q <= in_data;
    end
    if (cmd.op == DP_OUT) begin
      out_q.phase       <= cmd.phase;
      out_q.drive_angle <= angle_reg;
      out_q.drive_speed <= speed_reg;
      out_q.is_done     <= (cmd.phase == PH_DONE);
    end
  end

  // sequencer state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      align_count  <= '0;
      ramp_count   <= '0;
      switch_count <= '0;
      ramp_freq    <= '0;
      angle_reg    <= '0;
      speed_reg    <= '0;
      mix_weight   <= '0;
      rem          <= '0;
      acc          <= '0;
    end else begin
      unique case (cmd.op)
        DP_START: begin
          align_count  <= '0;
          ramp_freq    <= freq_start;
          ramp_count   <= '0;
          switch_count <= '0;
          mix_weight   <= '0;
          angle_reg    <= '0;
          speed_reg    <= '0;
        end
        DP_ALIGN: begin
          align_count <= align_inc;
          angle_reg   <= '0;
          speed_reg   <= '0;
          if (align_inc >= align_ticks) begin
            ramp_freq <= freq_start;
          end
        end
        DP_RAMP_FREQ: begin
          ramp_freq <= freq_new;
          speed_reg <= freq_new;
        end
        DP_RAMP_ANGLE: begin
          angle_reg  <= angle_reg + prod[ANG_SHIFT +: ANGLE_W];
          ramp_count <= ramp_count + 1'b1;
          if (mid_lhs >= mid_rhs && in_q.observer_converged) begin
            switch_count <= '0;
            mix_weight   <= '0;
          end
        end
        DP_SW_COUNT: begin
          switch_count <= switch_count + 1'b1;
        end
        DP_W_ONE: begin
          mix_weight <= WEIGHT_ONE;
        end
        DP_DIV_INIT: begin
          rem        <= switch_count;
          mix_weight <= '0;
        end
        DP_DIV_STEP: begin
          rem        <= div_ge ? rem_diff[COUNT_W-1:0] : rem2[COUNT_W-1:0];
          mix_weight <= {mix_weight[WEIGHT_W-2:0], div_ge};
        end
        DP_MUL_A1, DP_MUL_S1: begin
          acc <= prod;
        end
        DP_ACC_A: begin
          angle_reg <= blend_sum[DIV_STEPS +: ANGLE_W];
        end
        DP_ACC_S: begin
          speed_reg <= blend_sum[DIV_STEPS +: FREQ_W];
        end
        DP_DONE_TRK: begin
          angle_reg <= in_q.observer_angle;
          speed_reg <= in_q.observer_speed;
        end
        default: ;
      endcase
    end
  end

  // status to the controller
  assign stat.func      = in_q.func;
  assign stat.conv      = in_q.observer_converged;
  assign stat.align_hit = align_inc >= align_ticks;
  assign stat.mid_hit   = mid_lhs >= mid_rhs;
  assign stat.timeout   = ramp_count >= RAMP_CNT_W'(RAMP_TIMEOUT);
  assign stat.sw_last   = switch_count >= switch_ticks;

  assign out_data = out_q;

  // checks
  `include "sensorless_motor_startup_sequencer_core_assert.svh"

  `SMSS_ASSERT_IMPL(a_weight_range, clk, rst, 1'b1, mix_weight <= WEIGHT_ONE)
  `SMSS_ASSERT_IMPL(a_ramp_count_range, clk, rst, 1'b1,
    ramp_count <= RAMP_CNT_W'(RAMP_TIMEOUT + 1))
  `SMSS_ASSERT_NEXT(a_div_rem_below, clk, rst, cmd.op == DP_DIV_INIT, rem < switch_ticks)

endmodule

`default_nettype wire

FILE: rtl/smss_ctrl.sv
`default_nettype none

module smss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  smss_pkg::dp_stat_t  stat,
  output smss_pkg::dp_cmd_t   cmd
);
  import smss_pkg::*;

  ctrl_state_t           state;
  ctrl_state_t           state_next;
  phase_t                phase;
  phase_t                phase_next;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [DIV_CNT_W-1:0]  div_cnt_next;
  logic                  out_full;
  logic                  out_full_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IDLE;
      div_cnt  <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      div_cnt  <= div_cnt_next;
      out_full <= out_full_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = out_full;

  // next state and commands
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    div_cnt_next  = div_cnt;
    out_full_next = out_full && out_stall;
    cmd.op        = DP_NOP;
    cmd.ld_in     = 1'b0;
    cmd.phase     = phase;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_EMIT;
        unique case (stat.func)
          FUNC_START: begin
            cmd.op     = DP_START;
            phase_next = PH_ALIGN;
          end
          FUNC_STOP: begin
            phase_next = PH_IDLE;
          end
          FUNC_TICK: begin
            unique case (phase)
              PH_ALIGN: begin
                cmd.op = DP_ALIGN;
                if (stat.align_hit) begin
                  phase_next = PH_RAMP;
                end
              end
              PH_RAMP: begin
                cmd.op     = DP_RAMP_FREQ;
                state_next = S_RAMP_MUL;
              end
              PH_SWITCH: begin
                cmd.op     = DP_SW_COUNT;
                state_next = S_SW_WEIGHT;
              end
              PH_DONE: begin
                cmd.op = DP_DONE_TRK;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_RAMP_MUL: begin
        cmd.op     = DP_RAMP_MUL;
        state_next = S_RAMP_ANGLE;
      end
      S_RAMP_ANGLE: begin
        cmd.op     = DP_RAMP_ANGLE;
        state_next = S_EMIT;
        if (stat.timeout) begin
          phase_next = PH_ERROR;
        end else if (stat.mid_hit && stat.conv) begin
          phase_next = PH_SWITCH;
        end
      end
      S_SW_WEIGHT: begin
        if (stat.sw_last) begin
          cmd.op     = DP_W_ONE;
          state_next = S_MUL_A0;
        end else begin
          cmd.op       = DP_DIV_INIT;
          div_cnt_next = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op       = DP_DIV_STEP;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_MUL_A0;
        end
      end
      S_MUL_A0: begin
        cmd.op     = DP_MUL_A0;
        state_next = S_MUL_A1;
      end
      S_MUL_A1: begin
        cmd.op     = DP_MUL_A1;
        state_next = S_ACC_A;
      end
      S_ACC_A: begin
        cmd.op     = DP_ACC_A;
        state_next = S_MUL_S0;
      end
      S_MUL_S0: begin
        cmd.op     = DP_MUL_S0;
        state_next = S_MUL_S1;
      end
      S_MUL_S1: begin
        cmd.op     = DP_MUL_S1;
        state_next = S_ACC_S;
      end
      S_ACC_S: begin
        cmd.op     = DP_ACC_S;
        state_next = S_EMIT;
        if (stat.sw_last) begin
          phase_next = PH_DONE;
        end
      end
      S_EMIT: begin
        if (!out_full || !out_stall) begin
          cmd.op        = DP_OUT;
          out_full_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  `include "sensorless_motor_startup_sequencer_core_assert.svh"

  `SMSS_ASSERT_IMPL(a_result_from_emit, clk, rst, $rose(out_full),
    $past(state) == S_EMIT)
  `SMSS_ASSERT_NEXT(a_div_runs_full, clk, rst, state == S_DIV && div_cnt != DIV_LAST,
    state == S_DIV)
  `SMSS_ASSERT_IMPL(a_phase_change_point, clk, rst, phase != $past(phase),
    $past(state) == S_DECODE || $past(state) == S_RAMP_ANGLE || $past(state) == S_ACC_S)

endmodule

`default_nettype wire

FILE: rtl/sensorless_motor_startup_sequencer_core.sv
// channel   direction  payload   handshake
// in        input      in_t      in_valid / in_stall
// out       output     out_t     out_valid / out_stall
// cfg       input      3b + 32b  cfg_we, no wait
//
// start, stop, align and done ticks go from accept via decode to emit;
// ramp ticks add a multiply and an angle update; switch ticks add the
// blends and, below full weight, the 16-step serial divider (worst case).
// rst is synchronous and active high; config and state registers reset.
// a waiting result does not block the next accept; out_stall holds the
// next result in the controller until the output register frees.
`default_nettype none

module sensorless_motor_startup_sequencer_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  smss_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output smss_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [smss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import smss_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing control
  smss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and state
  smss_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
